/* rtl/ehf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehf_pkg
// Shared types, codes and constants of the Ethernet IPv4/ARP header filter.
// ----------------------------------------------------------------------------
package ehf_pkg;

  localparam int unsigned MacW     = 48;
  localparam int unsigned LenW     = 16;
  localparam int unsigned PosW     = 5;
  localparam int unsigned CfgAddrW = 2;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_OWN_MAC = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_MIN_LEN = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_MAX_LEN = 2'd2;

  // Reset values of the configuration registers
  localparam logic [MacW-1:0] OWN_MAC_RST = '0;
  localparam logic [LenW-1:0] MIN_LEN_RST = 16'd42;
  localparam logic [LenW-1:0] MAX_LEN_RST = 16'd1514;

  // Header constants
  localparam logic [LenW-1:0] ETH_HDR_LEN   = 16'd14;
  localparam logic [LenW-1:0] ARP_FRAME_LEN = 16'd42;
  localparam logic [PosW-1:0] LAST_HDR_POS  = 5'd23;

  // Header byte values
  localparam logic [7:0] ETYPE_HI      = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
  localparam logic [7:0] ETYPE_ARP_LO  = 8'h06;
  localparam logic [7:0] IP_VER_IHL    = 8'h45;
  localparam logic [7:0] IP_DF         = 8'h40;
  localparam logic [7:0] PROTO_ICMP    = 8'd1;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] ARP_HTYPE_HI  = 8'h00;
  localparam logic [7:0] ARP_HTYPE_LO  = 8'h01;
  localparam logic [7:0] ARP_HLEN      = 8'd6;
  localparam logic [7:0] ARP_PLEN      = 8'd4;
  localparam logic [7:0] BCAST_BYTE    = 8'hFF;

  typedef enum logic [1:0] {
    VERDICT_REJECT = 2'd0,
    VERDICT_IPV4   = 2'd1,
    VERDICT_ARP    = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [MacW-1:0] own_mac;
    logic [LenW-1:0] min_len;
    logic [LenW-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic            active;
    logic [PosW-1:0] pos;
    logic            bcast;
    logic            is_arp;
    logic [LenW-1:0] len_sum;
  } flt_state_t;

  typedef struct packed {
    verdict_t        verdict;
    logic [LenW-1:0] frame_len;
  } result_t;

  // Byte k of the own MAC, byte 0 being the most significant
  function automatic logic [7:0] mac_byte(input logic [MacW-1:0] mac, input logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      3'd5:    b = mac[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/ethernet_ip_arp_header_filter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_ip_arp_header_filter_unit
// Checks the first 24 header bytes of each frame (destination MAC, EtherType,
// IPv4 or ARP header start) and emits at most one verdict per frame.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | tdata: data_byte; tuser: frame_start
// out_    | out | out_tvalid/tready  | tdata: frame_length; tuser: verdict
// cfg_    | in  | cfg_we             | cfg_addr selects register, cfg_wdata
//
// Flow: one byte per cycle while the result register can take a verdict;
// a byte goes from the input register through the header check into the
// result register when it gives a verdict.
// Reset: synchronous, active low; clears the frame state, valid flags and
// loads the default configuration (own MAC 0, min 42, max 1514).
// Stalls: a held verdict only blocks the input when the next byte cannot
// advance because the result register is full and not being taken.
// ----------------------------------------------------------------------------
module ethernet_ip_arp_header_filter_unit
  import ehf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input byte stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic [0:0]          in_tuser,   // [0] frame_start
  // verdict stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,  // [15:0] frame_length
  output logic [1:0]          out_tuser,  // [1:0] verdict
  // configuration writes
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [MacW-1:0]     cfg_wdata
);

  cfg_t       cfg_r;
  flt_state_t state_r;
  flt_state_t state_nxt;

  // input register
  logic       s1_valid_r;
  logic       s1_start_r;
  logic [7:0] s1_byte_r;

  logic       s1_adv;
  logic       in_fire;
  logic       res_valid;
  result_t    res;
  logic       can_take;
  result_t    out_res;

  // Configuration registers: the user must write them only while the filter is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_mac <= OWN_MAC_RST;
      cfg_r.min_len <= MIN_LEN_RST;
      cfg_r.max_len <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OWN_MAC: cfg_r.own_mac <= cfg_wdata;
        REG_MIN_LEN: cfg_r.min_len <= cfg_wdata[LenW-1:0];
        REG_MAX_LEN: cfg_r.max_len <= cfg_wdata[LenW-1:0];
        default:     cfg_r         <= cfg_r;
      endcase
    end
  end

  // Advance the registered byte whenever the result register can take a
  // verdict; bytes that give no verdict pass just the same.
  assign s1_adv    = s1_valid_r && can_take;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_start_r <= in_tuser[0];
      s1_byte_r  <= in_tdata;
    end
  end

  ehf_byte_check u_check (
    .cfg         (cfg_r),
    .state       (state_r),
    .frame_start (s1_start_r),
    .data_byte   (s1_byte_r),
    .state_nxt   (state_nxt),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Frame state: commit the check's update as the byte leaves the register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  ehf_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv && res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.frame_len;
  assign out_tuser = out_res.verdict;

endmodule

/* rtl/ehf_byte_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehf_byte_check
// Combinational check of one header byte against the frame state.
// ----------------------------------------------------------------------------
module ehf_byte_check
  import ehf_pkg::*;
(
  input  cfg_t       cfg,
  input  flt_state_t state,
  input  logic       frame_start,
  input  logic [7:0] data_byte,
  output flt_state_t state_nxt,
  output logic       res_valid,
  output result_t    res
);

  flt_state_t       eff;
  logic             fail;
  logic             done;
  logic [LenW-1:0]  len_add;
  logic [7:0]       want;

  always_comb begin
    eff = state;
    if (frame_start) begin
      eff = '{active: 1'b1, pos: '0, bcast: 1'b0, is_arp: 1'b0, len_sum: '0};
    end
  end

  assign len_add = eff.len_sum + {8'h00, data_byte} + ETH_HDR_LEN;
  assign want    = eff.bcast ? 8'hFF : mac_byte(cfg.own_mac, eff.pos[2:0]);

  always_comb begin
    state_nxt = eff;
    fail      = 1'b0;
    done      = 1'b0;
    priority if (eff.pos == 5'd0) begin
      if (data_byte == mac_byte(cfg.own_mac, 3'd0)) begin
        state_nxt.bcast = 1'b0;
      end else if (data_byte == 8'hFF) begin
        state_nxt.bcast = 1'b1;
      end else begin
        fail = 1'b1;
      end
    end else if (eff.pos <= 5'd5) begin
      fail = (data_byte != want);
    end else if (eff.pos == 5'd12) begin
      fail = (data_byte != 8'h08);
    end else if (eff.pos == 5'd13) begin
      if (data_byte == 8'h00) begin
        state_nxt.is_arp = 1'b0;
      end else if (data_byte == 8'h06) begin
        state_nxt.is_arp = 1'b1;
      end else begin
        fail = 1'b1;
      end
    end else if (eff.pos >= 5'd14 && eff.is_arp) begin
      case (eff.pos)
        5'd14:        fail = (data_byte != 8'h00);
        5'd15:        fail = (data_byte != 8'h01);
        5'd16:        fail = (data_byte != 8'h08);
        5'd17:        fail = (data_byte != 8'h00);
        5'd18:        fail = (data_byte != 8'h06);
        5'd19:        fail = (data_byte != 8'h04);
        LAST_HDR_POS: done = 1'b1;
        default:      fail = 1'b0;
      endcase
    end else if (eff.pos >= 5'd14) begin
      case (eff.pos)
        5'd14: fail = (data_byte != 8'h45);
        5'd16: state_nxt.len_sum = {data_byte, 8'h00};
        5'd17: begin
          state_nxt.len_sum = len_add;
          fail = (len_add == '0) || (len_add < cfg.min_len) || (len_add > cfg.max_len);
        end
        5'd20: fail = ((data_byte & 8'hBF) != 8'h00);
        5'd21: fail = (data_byte != 8'h00);
        LAST_HDR_POS: begin
          if (data_byte == 8'd1 || data_byte == 8'd17) begin
            done = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        default: fail = 1'b0;
      endcase
    end else begin
      fail = 1'b0;
    end

    if (!eff.active) begin
      // no frame open: hold state, drop the byte
      state_nxt = eff;
      fail      = 1'b0;
      done      = 1'b0;
    end else if (fail || done) begin
      state_nxt.active = 1'b0;
    end else begin
      state_nxt.pos = eff.pos + 5'd1;
    end
  end

  always_comb begin
    res_valid = fail || done;
    if (fail) begin
      res = '{verdict: VERDICT_REJECT, frame_len: '0};
    end else if (state_nxt.is_arp) begin
      res = '{verdict: VERDICT_ARP, frame_len: ARP_FRAME_LEN};
    end else begin
      res = '{verdict: VERDICT_IPV4, frame_len: state_nxt.len_sum};
    end
  end

endmodule

/* rtl/ehf_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehf_out_reg
// Result register of the filter: holds one verdict until the sink takes it.
// ----------------------------------------------------------------------------
module ehf_out_reg
  import ehf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    can_take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* rtl/ehf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehf_checker
// Port-level assertions on the verdict stream of the header filter.
// ----------------------------------------------------------------------------
module ehf_checker
  import ehf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a stalled verdict holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("verdict changed while stalled");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("verdict presented right after reset");

  a_reject_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == VERDICT_REJECT |-> out_tdata == '0)
    else $error("rejected frame with nonzero length");

  a_arp_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == VERDICT_ARP |-> out_tdata == ARP_FRAME_LEN)
    else $error("ARP verdict with wrong length");

  a_ipv4_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == VERDICT_IPV4 |-> out_tdata != '0)
    else $error("IPv4 verdict with zero length");

endmodule

bind ethernet_ip_arp_header_filter_unit ehf_checker u_ehf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Frame header filter test: feeds directed and random frame bytes through
// the input stream, predicts each verdict from its own model of the header
// checks, and compares every verdict leaving the output stream in order.
// ----------------------------------------------------------------------------

// Verdict scoreboard: tracks the header check state per request and queues
// the verdicts the block must produce.
class verdict_scoreboard;

  typedef enum {HDR_MORE, HDR_FAIL, HDR_DONE} hdr_step_t;

  logic [47:0] own_mac;
  logic [15:0] min_len;
  logic [15:0] max_len;

  logic        active;
  logic [4:0]  pos;
  logic        bcast;
  logic        is_arp;
  logic [15:0] len_sum;

  ehf_pkg::result_t verdicts_due[$];
  int unsigned      n_errors;

  function new();
    own_mac  = ehf_pkg::OWN_MAC_RST;
    min_len  = ehf_pkg::MIN_LEN_RST;
    max_len  = ehf_pkg::MAX_LEN_RST;
    active   = 1'b0;
    pos      = '0;
    bcast    = 1'b0;
    is_arp   = 1'b0;
    len_sum  = '0;
    n_errors = 0;
  endfunction

  function void set_reg(logic [ehf_pkg::CfgAddrW-1:0] idx, logic [47:0] val);
    case (idx)
      ehf_pkg::REG_OWN_MAC: own_mac = val;
      ehf_pkg::REG_MIN_LEN: min_len = val[15:0];
      ehf_pkg::REG_MAX_LEN: max_len = val[15:0];
      default: ;
    endcase
  endfunction

  function void flag(string msg);
    n_errors++;
    if (n_errors <= 10) $display("tb: mismatch: %s", msg);
  endfunction

  // Advance the header check by one accepted request byte
  function void note_request(logic start, logic [7:0] b);
    hdr_step_t        step;
    logic [7:0]       want;
    ehf_pkg::result_t r;
    if (start) begin
      active  = 1'b1;
      pos     = '0;
      bcast   = 1'b0;
      is_arp  = 1'b0;
      len_sum = '0;
    end
    if (!active) return;
    step = HDR_MORE;
    if (pos == 0) begin
      // own address wins even when its first byte is the broadcast byte
      if (b == own_mac[47:40]) bcast = 1'b0;
      else if (b == ehf_pkg::BCAST_BYTE) bcast = 1'b1;
      else step = HDR_FAIL;
    end else if (pos <= 5) begin
      want = bcast ? ehf_pkg::BCAST_BYTE : own_mac[8 * (5 - int'(pos)) +: 8];
      if (b != want) step = HDR_FAIL;
    end else if (pos == 12) begin
      if (b != ehf_pkg::ETYPE_HI) step = HDR_FAIL;
    end else if (pos == 13) begin
      if (b == ehf_pkg::ETYPE_IPV4_LO) is_arp = 1'b0;
      else if (b == ehf_pkg::ETYPE_ARP_LO) is_arp = 1'b1;
      else step = HDR_FAIL;
    end else if (pos >= 14 && is_arp) begin
      case (pos)
        5'd14: if (b != ehf_pkg::ARP_HTYPE_HI) step = HDR_FAIL;
        5'd15: if (b != ehf_pkg::ARP_HTYPE_LO) step = HDR_FAIL;
        5'd16: if (b != ehf_pkg::ETYPE_HI) step = HDR_FAIL;
        5'd17: if (b != ehf_pkg::ETYPE_IPV4_LO) step = HDR_FAIL;
        5'd18: if (b != ehf_pkg::ARP_HLEN) step = HDR_FAIL;
        5'd19: if (b != ehf_pkg::ARP_PLEN) step = HDR_FAIL;
        5'd23: step = HDR_DONE;
        default: ;
      endcase
    end else if (pos >= 14) begin
      case (pos)
        5'd14: if (b != ehf_pkg::IP_VER_IHL) step = HDR_FAIL;
        5'd16: len_sum = {b, 8'h00};
        5'd17: begin
          len_sum = len_sum + {8'h00, b} + ehf_pkg::ETH_HDR_LEN;
          if (len_sum == 0 || len_sum < min_len || len_sum > max_len) step = HDR_FAIL;
        end
        5'd20: if ((b & ~ehf_pkg::IP_DF) != 8'h00) step = HDR_FAIL;
        5'd21: if (b != 8'h00) step = HDR_FAIL;
        5'd23: begin
          step = (b == ehf_pkg::PROTO_ICMP || b == ehf_pkg::PROTO_UDP) ? HDR_DONE
                                                                       : HDR_FAIL;
        end
        default: ;
      endcase
    end
    if (step == HDR_MORE) begin
      pos++;
      return;
    end
    active = 1'b0;
    if (step == HDR_FAIL) begin
      r.verdict   = ehf_pkg::VERDICT_REJECT;
      r.frame_len = '0;
    end else if (is_arp) begin
      r.verdict   = ehf_pkg::VERDICT_ARP;
      r.frame_len = ehf_pkg::ARP_FRAME_LEN;
    end else begin
      r.verdict   = ehf_pkg::VERDICT_IPV4;
      r.frame_len = len_sum;
    end
    verdicts_due.push_back(r);
  endfunction

  // Compare one accepted verdict with the oldest prediction
  function void check_verdict(logic [1:0] verdict, logic [15:0] frame_len);
    ehf_pkg::result_t r;
    if (verdicts_due.size() == 0) begin
      flag($sformatf("verdict %0d length %0d with none due", verdict, frame_len));
      return;
    end
    r = verdicts_due.pop_front();
    if (verdict !== r.verdict)
      flag($sformatf("verdict exp %0d got %0d", r.verdict, verdict));
    if (frame_len !== r.frame_len)
      flag($sformatf("frame_length exp %0d got %0d", r.frame_len, frame_len));
  endfunction

endclass

module tb;
  import ehf_pkg::*;

  localparam int unsigned STUCK_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int unsigned PHASE_BYTES  = 75;
  localparam int unsigned N_PHASES     = 7;
  localparam int unsigned DRAIN_CYCLES = 4;     // verdict trails its request through the input and result registers

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic [0:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;
  logic [1:0]          out_tuser;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [MacW-1:0]     cfg_wdata;

  verdict_scoreboard sb;
  bit                idling;        // random gaps on both streams when set
  int unsigned       bytes_sent;
  int unsigned       stuck_cycles;

  ethernet_ip_arp_header_filter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Sample both streams at the rising edge; requests are noted before the
  // verdict check since a verdict always trails its request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tuser[0], in_tdata);
      if (out_tvalid && out_tready) sb.check_verdict(out_tuser, out_tdata);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver side: hold tready low for random bursts while idling is on
  initial begin
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (idling && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // Offer one request byte and hold it until taken; may insert a gap first
  task automatic send_byte(input logic start, input logic [7:0] b);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= start;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Write one register; the block must be idle
  task automatic write_cfg(input logic [CfgAddrW-1:0] idx, input logic [MacW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Stop requests, wait for every verdict due, then let the pipe empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One random frame: mostly well-formed IPv4 or ARP headers with random
  // content, some with a corrupted byte, some pure noise; sometimes cut
  // short (next start restarts it) or preceded by stray bytes.
  task automatic send_frame();
    logic [7:0]  hdr [24];
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] sum;
    logic [15:0] total;
    int          kind;
    int          dst;
    int          n;
    int          idx;
    bit          arp;
    lo = sb.min_len;
    hi = sb.max_len;
    kind = $urandom_range(0, 9);  // 0-3 IPv4, 4-6 ARP, 7-8 corrupted, 9 noise
    for (int i = 0; i < 24; i++) hdr[i] = 8'($urandom);
    if (kind != 9) begin
      dst = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++) begin
        if (dst < 6) hdr[i] = sb.own_mac[8 * (5 - i) +: 8];
        else if (dst < 9) hdr[i] = 8'hFF;
      end
      arp = (kind >= 4 && kind <= 6) || (kind >= 7 && $urandom_range(0, 1) == 1);
      hdr[12] = ETYPE_HI;
      if (arp) begin
        hdr[13] = ETYPE_ARP_LO;
        hdr[14] = ARP_HTYPE_HI;
        hdr[15] = ARP_HTYPE_LO;
        hdr[16] = ETYPE_HI;
        hdr[17] = ETYPE_IPV4_LO;
        hdr[18] = ARP_HLEN;
        hdr[19] = ARP_PLEN;
      end else begin
        hdr[13] = ETYPE_IPV4_LO;
        hdr[14] = IP_VER_IHL;
        // aim the length at the bounds, their edges and the wrap to zero
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: sum = (lo <= hi) ? 16'($urandom_range(hi, lo)) : 16'($urandom);
          5:             sum = lo;
          6:             sum = hi;
          7:             sum = lo - 16'd1;
          8:             sum = hi + 16'd1;
          default:       sum = ($urandom_range(0, 1) == 1) ? 16'h0000 : 16'($urandom);
        endcase
        total   = sum - ETH_HDR_LEN;
        hdr[16] = total[15:8];
        hdr[17] = total[7:0];
        hdr[20] = ($urandom_range(0, 1) == 1) ? IP_DF : 8'h00;
        hdr[21] = 8'h00;
        hdr[23] = ($urandom_range(0, 1) == 1) ? PROTO_ICMP : PROTO_UDP;
      end
      if (kind >= 7) begin
        idx = $urandom_range(0, 23);
        hdr[idx] = hdr[idx] ^ 8'($urandom_range(1, 255));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom));
    end
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 23) : 24;
    for (int i = 0; i < n; i++) begin
      send_byte((i == 0) || (kind == 9 && $urandom_range(0, 15) == 0), hdr[i]);
    end
    if (n == 24) begin
      repeat ($urandom_range(0, 3)) send_byte(1'b0, 8'($urandom));
    end
  endtask

  initial begin
    logic [MacW-1:0] mac;
    logic [LenW-1:0] mn;
    logic [LenW-1:0] mx;
    sb           = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_we       = 1'b0;
    cfg_addr     = REG_OWN_MAC;
    cfg_wdata    = '0;
    idling       = 1'b1;
    bytes_sent   = 0;
    stuck_cycles = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset configuration (own MAC all zero).
    // stray bytes before any frame: ignored
    send_byte(1'b0, 8'hA5);
    send_byte(1'b0, 8'h00);
    // own address start, then restart mid-frame onto broadcast, fail at byte 2
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'h00);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00);
    // byte after a verdict: ignored
    send_byte(1'b0, 8'hFF);
    // first byte neither own nor broadcast
    send_byte(1'b1, 8'h7E);
    // broadcast header with an unknown EtherType
    send_byte(1'b1, 8'hFF);
    repeat (5) send_byte(1'b0, 8'hFF);
    repeat (6) send_byte(1'b0, 8'h5A);
    send_byte(1'b0, ETYPE_HI);
    send_byte(1'b0, 8'h01);

    // Random phases, each under its own register setting; the last one
    // runs without gaps on either stream.
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1:       begin mac = {16'($urandom), 32'($urandom)}; mn = 16'd0;    mx = 16'hFFFF; end
          2:       begin mac = '1;                             mn = 16'd42;   mx = 16'd1514; end
          3:       begin mac = '0;                             mn = 16'd1500; mx = 16'd100;  end
          4:       begin mac = {16'($urandom), 32'($urandom)}; mn = 16'hFFFF; mx = 16'hFFFF; end
          5:       begin mac = {8'hFF, 8'($urandom), 32'($urandom)}; mn = 16'd60; mx = 16'd60; end
          default: begin mac = {16'($urandom), 32'($urandom)}; mn = 16'd42;   mx = 16'd1514; end
        endcase
        write_cfg(REG_OWN_MAC, mac);
        write_cfg(REG_MIN_LEN, {32'h0, mn});
        write_cfg(REG_MAX_LEN, {32'h0, mx});
      end
      idling = (p != N_PHASES - 1);
      mn = 16'(bytes_sent + PHASE_BYTES);
      while (bytes_sent < mn) send_frame();
    end

    drain();
    if (sb.n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
